// ===== src/t2u_pkg.sv =====
// t2u_pkg: beat types, character codes and digit decoding for the
// text-to-unsigned parser. No dependencies; imported by text_to_unsigned_parser.
package t2u_pkg;

   // Default word and offset counter widths
   localparam int WORD_BITS_DEFAULT   = 32;
   localparam int OFFSET_BITS_DEFAULT = 16;

   // Radix register
   localparam int         RADIX_BITS  = 6;
   localparam logic [5:0] RADIX_RESET = 6'd10;
   localparam logic [5:0] RADIX_AUTO  = 6'd0;
   localparam logic [5:0] RADIX_MIN   = 6'd2;
   localparam logic [5:0] RADIX_MAX   = 6'd36;
   localparam logic [5:0] RADIX_OCT   = 6'd8;
   localparam logic [5:0] RADIX_DEC   = 6'd10;
   localparam logic [5:0] RADIX_HEX   = 6'd16;

   // Character codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UC_X  = 8'h58;
   localparam logic [7:0] CHAR_LC_X  = 8'h78;

   // Digit value that no radix accepts
   localparam logic [6:0] DIGIT_NONE = 7'd99;

   // Input beat
   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [31:0] value;
      logic [15:0] end_offset;
      logic        converted;
      logic        overflow;
   } rsp_type;

   // Whitespace: space, tab, LF, VT, FF, CR
   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // Value of a digit or letter, DIGIT_NONE for anything else
   function automatic logic [6:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = {1'b0, DIGIT_NONE};
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         d = c - CHAR_UC_A + 8'd10;
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         d = c - CHAR_LC_A + 8'd10;
      end
      return d[6:0];
   endfunction

endpackage

// ===== src/text_to_unsigned_parser.sv =====
// text_to_unsigned_parser: streaming character-to-unsigned converter.
// Depends on t2u_pkg (beat types, character codes, digit decoding).
//
// Usage
//   req channel: one character per beat; first=1 starts a new string and
//   that character is offset 0. Leading whitespace, one sign and a 0x/0X
//   prefix (radix 0 or 16) are taken, then digits below the radix.
//   rsp channel: at most one beat per string, issued on the character that ends
//   the number: value, offset of that character (0 if none converted), converted
//   and overflow flags. Characters after it give nothing until the next first=1.
//   csr channel: writes the radix (0 = detect from prefix, 2..36 fixed);
//   always ready, sampled when a string starts.
// Timing
//   One character per cycle sustained while no result waits on rsp_ready. A
//   beat is worked on while it sits in the input register, and the result is
//   then loaded into the output register. The work on each character is a
//   multiply-add of the accumulator by the radix.
// Reset and stalls
//   Reset empties both registers, sets the radix to 10 and waits for a
//   first=1. While a result waits on rsp_ready the input register holds
//   one more beat and req_ready drops once it is full.
module text_to_unsigned_parser
   import t2u_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEFAULT,
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_BITS-1:0] csr_data
);

   localparam int ProdW = WORD_BITS + RADIX_BITS + 1;
   localparam logic [WORD_BITS-1:0]   WordMax = {WORD_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] PosMax  = {OFFSET_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_DONE, PH_SPACE, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE, ST_SOME, ST_OVER
   } status_type;

   // Registers
   logic                   in_valid_ff;
   req_type                in_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [RADIX_BITS-1:0]  radix_ff;
   phase_type              phase_ff, phase_in;
   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   status_type             status_ff, status_in;
   logic [RADIX_BITS-1:0]  aradix_ff, aradix_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   // Working signals
   logic                   process;
   logic [7:0]             c;
   phase_type              ph_s;
   logic [WORD_BITS-1:0]   acc_s, acc_t, val_w;
   logic                   neg_s;
   status_type             st_s, st_t;
   logic [RADIX_BITS-1:0]  ar_s, base_t;
   logic [OFFSET_BITS-1:0] pos_s, off_w;
   logic                   lead, take, fin, base_bad;
   logic [6:0]             dig;
   logic [ProdW-1:0]       prod;
   logic [WORD_BITS+31:0]  val_ext;
   logic [OFFSET_BITS+15:0] off_ext;

   // Work on the held beat once the output register can take a result
   assign process   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One character through the parser
   always_comb begin
      c = in_data_ff.ch;

      // Restart on first character
      if (in_data_ff.first) begin
         ph_s  = PH_SPACE;
         acc_s = '0;
         neg_s = 1'b0;
         st_s  = ST_NONE;
         ar_s  = radix_ff;
         pos_s = '0;
      end else begin
         ph_s  = phase_ff;
         acc_s = acc_ff;
         neg_s = neg_ff;
         st_s  = status_ff;
         ar_s  = aradix_ff;
         pos_s = pos_ff;
      end

      phase_in  = ph_s;
      neg_in    = neg_s;
      aradix_in = ar_s;
      pos_in    = pos_s;
      lead      = 1'b0;
      take      = 1'b0;
      base_t    = ar_s;
      acc_t     = acc_s;
      st_t      = st_s;

      // Advance the offset, holding at its maximum
      if (ph_s != PH_DONE && pos_s != PosMax) begin
         pos_in = pos_s + 1'b1;
      end

      unique case (ph_s)
         PH_SPACE: begin
            if (is_space(c)) begin
               phase_in = PH_SPACE;
            end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
               neg_in   = (c == CHAR_MINUS);
               phase_in = PH_SIGNED;
            end else begin
               lead = 1'b1;
            end
         end
         PH_SIGNED: begin
            lead = 1'b1;
         end
         PH_ZERO: begin
            if (c == CHAR_LC_X || c == CHAR_UC_X) begin
               aradix_in = RADIX_HEX;
               phase_in  = PH_PREFIX;
            end else begin
               // leading zero already counts as a digit
               base_t    = (ar_s == RADIX_AUTO) ? RADIX_OCT : ar_s;
               aradix_in = base_t;
               st_t      = ST_SOME;
               acc_t     = '0;
               phase_in  = PH_DIGITS;
               take      = 1'b1;
            end
         end
         PH_PREFIX, PH_DIGITS: begin
            phase_in = PH_DIGITS;
            take     = 1'b1;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // First character after whitespace and sign
      if (lead) begin
         if (c == CHAR_ZERO && (ar_s == RADIX_AUTO || ar_s == RADIX_HEX)) begin
            phase_in = PH_ZERO;
         end else begin
            base_t    = (ar_s == RADIX_AUTO) ? RADIX_DEC : ar_s;
            aradix_in = base_t;
            phase_in  = PH_DIGITS;
            take      = 1'b1;
         end
      end

      acc_in    = acc_t;
      status_in = st_t;

      // Multiply-add; any bit above the word means overflow
      dig  = digit_of(c);
      prod = ProdW'(acc_t) * ProdW'(base_t) + ProdW'(dig);
      base_bad = (base_t < RADIX_MIN) || (base_t > RADIX_MAX) ||
                 (dig >= {1'b0, base_t});
      fin = 1'b0;

      if (take) begin
         if (base_bad) begin
            fin      = 1'b1;
            phase_in = PH_DONE;
         end else if (st_t != ST_OVER) begin
            if (|prod[ProdW-1:WORD_BITS]) begin
               status_in = ST_OVER;
               acc_in    = WordMax;
            end else begin
               status_in = ST_SOME;
               acc_in    = prod[WORD_BITS-1:0];
            end
         end
      end

      // Build the result beat
      val_w   = (neg_s && st_t == ST_SOME) ? (~acc_t) + WORD_BITS'(1) : acc_t;
      off_w   = (st_t != ST_NONE) ? pos_s : '0;
      val_ext = {32'b0, val_w};
      off_ext = {16'b0, off_w};
      rsp_data_in.value      = val_ext[31:0];
      rsp_data_in.end_offset = off_ext[15:0];
      rsp_data_in.converted  = (st_t != ST_NONE);
      rsp_data_in.overflow   = (st_t == ST_OVER);

      // Load on a finishing beat, drop once taken
      if (process && fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State, input register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= RADIX_RESET;
         phase_ff     <= PH_DONE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         status_ff    <= ST_NONE;
         aradix_ff    <= '0;
         pos_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            radix_ff <= csr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            neg_ff    <= neg_in;
            status_ff <= status_in;
            aradix_ff <= aradix_in;
            pos_ff    <= pos_in;
         end
      end
      // Payload registers
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (process && fin) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
